// File: hw/rtl/bpr_pkg.sv
package bpr_pkg;

    localparam int BYTE_W    = 8;
    localparam int NIBBLE_W  = 4;
    localparam int ADDR_W    = 20;
    localparam int DIM_W     = 11;
    // wide enough for any raw dimension and any supported maximum (up to 4096)
    localparam int DIM_CMP_W = 13;
    localparam int PADDR_W   = 5;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_WIDTH_PX      = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_HEIGHT_PX     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_BOTTOM_TO_TOP = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_PACK_4BIT     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_COL_MAJOR     = 3'd4;

    localparam logic [DIM_W-1:0] RST_WIDTH_PX  = 11'd256;
    localparam logic [DIM_W-1:0] RST_HEIGHT_PX = 11'd192;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
    } in_beat_t;

    typedef struct packed {
        logic [ADDR_W-1:0] dest_address;
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_image;
    } out_beat_t;

    typedef struct packed {
        logic [DIM_W-1:0] width_px;
        logic [DIM_W-1:0] height_px;
        logic             bottom_to_top;
        logic             pack_4bit;
        logic             col_major;
    } cfg_t;

endpackage

// File: hw/rtl/bpr_stream_if.sv
interface bpr_stream_if #(
    parameter type beat_t = bpr_pkg::in_beat_t
) ();
    logic  valid;
    logic  ready;
    beat_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/bpr_cfg_regs.sv
module bpr_cfg_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bpr_pkg::PADDR_W-1:0]  paddr,
    input  logic [bpr_pkg::PDATA_W-1:0]  pwdata,
    output logic [bpr_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output bpr_pkg::cfg_t                cfg,
    output logic                         restart
);

    bpr_pkg::cfg_t cfg_reg;
    bpr_pkg::cfg_t cfg_next;
    logic [bpr_pkg::REG_IDX_W-1:0] idx;
    logic wr_en;

    assign idx    = paddr[bpr_pkg::PADDR_W-1:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        restart  = 1'b0;
        if (wr_en)
        begin
            case (idx)
                bpr_pkg::REG_WIDTH_PX:
                begin
                    cfg_next.width_px = pwdata[bpr_pkg::DIM_W-1:0];
                    restart = 1'b1;
                end
                bpr_pkg::REG_HEIGHT_PX:
                begin
                    cfg_next.height_px = pwdata[bpr_pkg::DIM_W-1:0];
                    restart = 1'b1;
                end
                bpr_pkg::REG_BOTTOM_TO_TOP:
                begin
                    cfg_next.bottom_to_top = pwdata[0];
                    restart = 1'b1;
                end
                bpr_pkg::REG_PACK_4BIT:
                begin
                    cfg_next.pack_4bit = pwdata[0];
                    restart = 1'b1;
                end
                bpr_pkg::REG_COL_MAJOR:
                begin
                    cfg_next.col_major = pwdata[0];
                    restart = 1'b1;
                end
                default:
                begin
                    // unmapped address, write dropped
                end
            endcase
        end
    end

    always_comb
    begin
        case (idx)
            bpr_pkg::REG_WIDTH_PX:      prdata = bpr_pkg::PDATA_W'(cfg_reg.width_px);
            bpr_pkg::REG_HEIGHT_PX:     prdata = bpr_pkg::PDATA_W'(cfg_reg.height_px);
            bpr_pkg::REG_BOTTOM_TO_TOP: prdata = bpr_pkg::PDATA_W'(cfg_reg.bottom_to_top);
            bpr_pkg::REG_PACK_4BIT:     prdata = bpr_pkg::PDATA_W'(cfg_reg.pack_4bit);
            bpr_pkg::REG_COL_MAJOR:     prdata = bpr_pkg::PDATA_W'(cfg_reg.col_major);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.width_px      <= bpr_pkg::RST_WIDTH_PX;
            cfg_reg.height_px     <= bpr_pkg::RST_HEIGHT_PX;
            cfg_reg.bottom_to_top <= 1'b1;
            cfg_reg.pack_4bit     <= 1'b0;
            cfg_reg.col_major     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: hw/rtl/bpr_scan.sv
module bpr_scan #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int OPND_W     = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpr_pkg::cfg_t               cfg,
    input  logic                        restart,
    input  logic                        in_valid,
    input  logic [bpr_pkg::BYTE_W-1:0]  in_byte,
    output logic                        in_ready,
    output logic                        s1_valid,
    input  logic                        s1_ready,
    output logic [OPND_W-1:0]           s1_mul_a,
    output logic [OPND_W-1:0]           s1_mul_b,
    output logic [OPND_W-1:0]           s1_add,
    output logic [bpr_pkg::BYTE_W-1:0]  s1_value,
    output logic                        s1_last
);

    localparam int CW = $clog2(MAX_WIDTH + 4);
    localparam int HW = $clog2(MAX_HEIGHT + 1);

    logic [CW-1:0] col_reg, col_next;
    logic [HW-1:0] row_reg, row_next;
    logic [bpr_pkg::NIBBLE_W-1:0] held_reg, held_next;
    logic s1_valid_reg, s1_valid_next;

    logic [OPND_W-1:0] mul_a_reg, mul_b_reg, add_reg;
    logic [bpr_pkg::BYTE_W-1:0] value_reg;
    logic last_reg;

    logic [bpr_pkg::DIM_CMP_W-1:0] w_raw, h_raw;
    logic [CW-1:0] w, padded, rw, last_col, x, xo, c_cur, c_inc;
    logic [HW-1:0] h, r_cur, r_inc, y;
    logic [bpr_pkg::BYTE_W-1:0] value;
    logic emit, last, acc;

    // clamp dimensions to 1..MAX
    always_comb
    begin
        w_raw = bpr_pkg::DIM_CMP_W'(cfg.width_px);
        h_raw = bpr_pkg::DIM_CMP_W'(cfg.height_px);
        if (w_raw == '0)
            w = CW'(1);
        else if (w_raw > bpr_pkg::DIM_CMP_W'(MAX_WIDTH))
            w = CW'(MAX_WIDTH);
        else
            w = CW'(w_raw);
        if (h_raw == '0)
            h = HW'(1);
        else if (h_raw > bpr_pkg::DIM_CMP_W'(MAX_HEIGHT))
            h = HW'(MAX_HEIGHT);
        else
            h = HW'(h_raw);
    end

    assign padded = (w + CW'(3)) & ~CW'(3);
    assign acc    = in_valid && in_ready;

    always_comb
    begin
        if (col_reg >= padded || row_reg >= h)
        begin
            c_cur = '0;
            r_cur = '0;
        end
        else
        begin
            c_cur = col_reg;
            r_cur = row_reg;
        end

        y = cfg.bottom_to_top ? (h - HW'(1) - r_cur) : r_cur;

        held_next = held_reg;
        if (cfg.pack_4bit)
        begin
            rw       = CW'((w + CW'(1)) >> 1);
            last_col = (w - CW'(1)) & ~CW'(1);
            if (!c_cur[0])
            begin
                if (acc && c_cur < w)
                    held_next = in_byte[bpr_pkg::NIBBLE_W-1:0];
                x     = '0;
                xo    = '0;
                value = '0;
                emit  = 1'b0;
            end
            else
            begin
                x     = c_cur - CW'(1);
                xo    = x >> 1;
                value = {held_reg, in_byte[bpr_pkg::NIBBLE_W-1:0]};
                emit  = (x < w);
            end
        end
        else
        begin
            rw       = w;
            last_col = w - CW'(1);
            x        = c_cur;
            xo       = c_cur;
            value    = in_byte;
            emit     = (c_cur < w);
        end

        last = (r_cur == h - HW'(1)) && (x == last_col);

        // advance the stored position, wrapping at the end of the padded image
        c_inc = c_cur + CW'(1);
        r_inc = r_cur + HW'(1);
        col_next = col_reg;
        row_next = row_reg;
        if (acc)
        begin
            if (c_inc >= padded)
            begin
                col_next = '0;
                row_next = (r_inc >= h) ? '0 : r_inc;
            end
            else
            begin
                col_next = c_inc;
                row_next = r_cur;
            end
        end

        if (restart)
        begin
            col_next  = '0;
            row_next  = '0;
            held_next = '0;
        end

        if (acc)
            s1_valid_next = emit;
        else if (s1_ready)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    assign in_ready = !s1_valid_reg || s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            held_reg     <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            held_reg     <= held_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    // operands for the address stage: row-major y*rw + xo, column-major xo*h + y
    always_ff @(posedge clk)
    begin
        if (acc && emit)
        begin
            mul_a_reg <= cfg.col_major ? OPND_W'(xo) : OPND_W'(y);
            mul_b_reg <= cfg.col_major ? OPND_W'(h) : OPND_W'(rw);
            add_reg   <= cfg.col_major ? OPND_W'(y) : OPND_W'(xo);
            value_reg <= value;
            last_reg  <= last;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_mul_a = mul_a_reg;
    assign s1_mul_b = mul_b_reg;
    assign s1_add   = add_reg;
    assign s1_value = value_reg;
    assign s1_last  = last_reg;

endmodule

// File: hw/rtl/bpr_addr_gen.sv
module bpr_addr_gen #(
    parameter int OPND_W = 11
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s1_valid,
    output logic                        s1_ready,
    input  logic [OPND_W-1:0]           s1_mul_a,
    input  logic [OPND_W-1:0]           s1_mul_b,
    input  logic [OPND_W-1:0]           s1_add,
    input  logic [bpr_pkg::BYTE_W-1:0]  s1_value,
    input  logic                        s1_last,
    output logic                        out_valid,
    input  logic                        out_ready,
    output bpr_pkg::out_beat_t          out_beat
);

    localparam int PROD_W = 2 * OPND_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  sum;
    logic out_valid_reg, out_valid_next;
    bpr_pkg::out_beat_t beat_reg;

    assign prod     = s1_mul_a * s1_mul_b;
    assign sum      = SUM_W'(prod) + SUM_W'(s1_add);
    assign s1_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        if (s1_valid && s1_ready)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // address wraps modulo 2^20
    always_ff @(posedge clk)
    begin
        if (s1_valid && s1_ready)
        begin
            beat_reg.dest_address  <= bpr_pkg::ADDR_W'(sum);
            beat_reg.out_byte      <= s1_value;
            beat_reg.last_of_image <= s1_last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = beat_reg;

endmodule

// File: hw/rtl/bmp_pixel_relayout_unit.sv
// an accepted pixel beat is registered in the scan stage, then in the output register
// throughput: one input beat per cycle while pix_out is not stalled; padding beats and
//   the first beat of each 4-bit pair produce no output beat; the scan counters and the
//   one address multiply are combinational ahead of their registers, so no stall is added internally
// reset (rst_n, async, active low): registers return to 256 x 192, bottom-to-top,
//   8-bit, row-major; scan position and held nibble cleared; pipeline emptied
module bmp_pixel_relayout_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpr_pkg::PADDR_W-1:0] paddr,
    input  logic [bpr_pkg::PDATA_W-1:0] pwdata,
    output logic [bpr_pkg::PDATA_W-1:0] prdata,
    output logic                        pready,
    bpr_stream_if.sink                  pix_in,
    bpr_stream_if.source                pix_out
);

    // column counter covers the padded row, row counter covers the height
    localparam int CW     = $clog2(MAX_WIDTH + 4);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int OPND_W = (CW > HW) ? CW : HW;

    bpr_pkg::cfg_t cfg;
    logic          restart;

    // stage 1 beat: operands of the address multiply-add plus payload
    logic                       s1_valid;
    logic                       s1_ready;
    logic [OPND_W-1:0]          s1_mul_a;
    logic [OPND_W-1:0]          s1_mul_b;
    logic [OPND_W-1:0]          s1_add;
    logic [bpr_pkg::BYTE_W-1:0] s1_value;
    logic                       s1_last;

    bpr_pkg::out_beat_t out_beat;

    // configuration registers; any write to a mapped register restarts the image scan
    bpr_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg),
        .restart (restart)
    );

    // stored column/row counters, row flip, nibble pairing, address operand select
    bpr_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .OPND_W     (OPND_W)
    ) u_scan (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .restart  (restart),
        .in_valid (pix_in.valid),
        .in_byte  (pix_in.data.pixel_byte),
        .in_ready (pix_in.ready),
        .s1_valid (s1_valid),
        .s1_ready (s1_ready),
        .s1_mul_a (s1_mul_a),
        .s1_mul_b (s1_mul_b),
        .s1_add   (s1_add),
        .s1_value (s1_value),
        .s1_last  (s1_last)
    );

    // multiply-add for the destination address, output register
    bpr_addr_gen #(
        .OPND_W (OPND_W)
    ) u_addr_gen (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_ready  (s1_ready),
        .s1_mul_a  (s1_mul_a),
        .s1_mul_b  (s1_mul_b),
        .s1_add    (s1_add),
        .s1_value  (s1_value),
        .s1_last   (s1_last),
        .out_valid (pix_out.valid),
        .out_ready (pix_out.ready),
        .out_beat  (out_beat)
    );

    assign pix_out.data = out_beat;

endmodule

// File: hw/rtl/bpr_checker.sv
module bpr_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpr_pkg::PADDR_W-1:0] paddr,
    input  logic [bpr_pkg::PDATA_W-1:0] pwdata,
    input  logic [bpr_pkg::PDATA_W-1:0] prdata,
    input  logic                        in_ready,
    input  logic                        out_valid,
    input  logic                        out_ready,
    input  bpr_pkg::out_beat_t          out_data
);

    // a stalled output beat stays and holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output beat dropped or changed while stalled");

    // with the output register empty the whole pipe drains, so input is open
    a_in_open: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output register");

    a_width_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[4:2] == bpr_pkg::REG_WIDTH_PX
        |=> paddr[4:2] != bpr_pkg::REG_WIDTH_PX
            || prdata[10:0] == $past(pwdata[10:0]))
        else $error("image width readback mismatch");

    a_pack_rb: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[4:2] == bpr_pkg::REG_PACK_4BIT
        |=> paddr[4:2] != bpr_pkg::REG_PACK_4BIT || prdata[0] == $past(pwdata[0]))
        else $error("pack mode readback mismatch");

endmodule

bind bmp_pixel_relayout_unit bpr_checker u_bpr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .in_ready  (pix_in.ready),
    .out_valid (pix_out.valid),
    .out_ready (pix_out.ready),
    .out_data  (pix_out.data)
);
